// ===== hw/rtl/llrb_pkg.sv =====
// Shared types and constants for the line log ring buffer.
`default_nettype none
package llrb_pkg;

    localparam int RING_LINES_DEF = 256;
    localparam int LINE_BYTES_DEF = 256;

    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 8;
    localparam int LINE_W  = 32;
    localparam int CHUNK_W = 5;
    localparam int TOTAL_W = 32;
    localparam int DATA_W  = 64;
    localparam int LANES   = 8;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;

    typedef enum logic [1:0] {
        OP_CAPTURE,
        OP_NEWLINE,
        OP_IGNORE,
        OP_READ
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_LOGGED = 2'd1,
        ST_WRAPPED    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CALC,
        BS_SLOT,
        BS_READ,
        BS_OUT
    } t_bstate;

    typedef struct packed {
        t_op                op;
        logic [CHAR_W-1:0]  ch;
        logic [LINE_W-1:0]  line;
        logic [CHUNK_W-1:0] chunk;
    } t_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/llrb_front.sv =====
// Front end: accepts input transactions, classifies them and queues the commands.
`default_nettype none
module llrb_front
    import llrb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_func,
    input  wire logic [CHAR_W-1:0]     i_char_byte,
    input  wire logic [LINE_W-1:0]     i_line_number,
    input  wire logic [CHUNK_W-1:0]    i_chunk_index,
    output logic                       o_cmd_valid,
    output t_cmd                       o_cmd,
    input  wire logic                  i_cmd_ready
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       cmd_in;
    logic       push;
    logic       pop;

    always_comb begin
        cmd_in.ch    = i_char_byte;
        cmd_in.line  = i_line_number;
        cmd_in.chunk = i_chunk_index;
        if (i_func) begin
            cmd_in.op = OP_READ;
        end else if (i_char_byte == CH_NEWLINE) begin
            cmd_in.op = OP_NEWLINE;
        end else if (i_char_byte == CH_RETURN) begin
            cmd_in.op = OP_IGNORE;
        end else begin
            cmd_in.op = OP_CAPTURE;
        end
    end

    assign o_in_ready  = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/llrb_back.sv =====
// Back end: executes captures, commits and reads against the ring memories.
`default_nettype none
module llrb_back
    import llrb_pkg::*;
#(
    parameter int RING_LINES = RING_LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    input  wire t_cmd                  i_cmd,
    output logic                       o_cmd_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [1:0]                 o_status,
    output logic [LEN_W-1:0]           o_line_length,
    output logic [DATA_W-1:0]          o_chunk_data,
    output logic [TOTAL_W-1:0]         o_lines_total
);

    // One physical slot more than the ring holds: the spare slot takes the line being built.
    localparam int PHYS      = RING_LINES + 1;
    localparam int SLOT_W    = $clog2(PHYS);
    localparam int NCHUNK    = (LINE_BYTES + 7) / 8;
    localparam int CW        = $clog2(NCHUNK);
    localparam int TXT_DEPTH = PHYS * (2 ** CW);
    localparam int ADDR_W    = SLOT_W + CW;
    localparam logic [LEN_W-1:0]   MAX_LEN  = LEN_W'(LINE_BYTES - 1);
    localparam logic [SLOT_W:0]    PHYS_X   = (SLOT_W + 1)'(PHYS);
    localparam logic [SLOT_W-1:0]  LAST_SLT = SLOT_W'(PHYS - 1);

    t_bstate             r_state, n_state;
    logic [LEN_W-1:0]    r_cur_len;
    logic [TOTAL_W-1:0]  r_total;
    logic [SLOT_W-1:0]   r_wp;
    logic [LINE_W-1:0]   r_line;
    logic [CHUNK_W-1:0]  r_chunk;
    logic                r_not_logged;
    logic [TOTAL_W-1:0]  r_dist;
    t_status             r_status;
    logic [SLOT_W-1:0]   r_slot;

    logic                r_ovalid;
    logic [1:0]          r_ostatus;
    logic [LEN_W-1:0]    r_olen;
    logic [DATA_W-1:0]   r_odata;
    logic [TOTAL_W-1:0]  r_ototal;

    logic [CHAR_W-1:0]   r_rd_lane [LANES];
    logic [LEN_W-1:0]    r_rd_len;
    logic [LEN_W-1:0]    r_len_mem [PHYS];

    logic                pop;
    logic                txt_we;
    logic [ADDR_W-1:0]   txt_waddr;
    logic [ADDR_W-1:0]   txt_raddr;
    logic                len_we;
    logic                load_out;
    logic [1:0]          out_status;
    logic [LEN_W-1:0]    out_len;
    logic [DATA_W-1:0]   out_data;
    logic [TOTAL_W-1:0]  out_total;
    logic                cap_ok;
    logic                can_commit;
    logic [SLOT_W:0]     wp_x;
    logic [SLOT_W:0]     dist_x;
    logic [SLOT_W:0]     slot_x;
    t_status             calc_status;
    logic [DATA_W-1:0]   masked_data;

    assign o_cmd_ready = (r_state == BS_IDLE) && (!r_ovalid || i_out_ready);
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign cap_ok      = (r_cur_len != MAX_LEN);
    assign can_commit  = (r_total != '1);

    assign txt_we    = pop && (i_cmd.op == OP_CAPTURE) && cap_ok;
    assign txt_waddr = {r_wp, r_cur_len[CW+2:3]};
    assign txt_raddr = {r_slot, r_chunk[CW-1:0]};
    assign len_we    = pop && (i_cmd.op == OP_NEWLINE) && can_commit;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [CHAR_W-1:0] r_txt_mem [TXT_DEPTH];
        always_ff @(posedge i_clk) begin
            if (txt_we && (r_cur_len[2:0] == 3'(k))) begin
                r_txt_mem[txt_waddr] <= i_cmd.ch;
            end
            r_rd_lane[k] <= r_txt_mem[txt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[r_wp] <= r_cur_len;
        end
        r_rd_len <= r_len_mem[r_slot];
    end

    always_comb begin
        wp_x   = {1'b0, r_wp};
        dist_x = {1'b0, r_dist[SLOT_W-1:0]};
        if (wp_x > dist_x) begin
            slot_x = wp_x - dist_x - 1'b1;
        end else begin
            slot_x = wp_x + PHYS_X - dist_x - 1'b1;
        end
        if (r_not_logged) begin
            calc_status = ST_NOT_LOGGED;
        end else if (r_dist >= TOTAL_W'(RING_LINES)) begin
            calc_status = ST_WRAPPED;
        end else begin
            calc_status = ST_OK;
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if ({r_chunk, 3'(k)} < r_rd_len) begin
                masked_data[k*8 +: 8] = r_rd_lane[k];
            end else begin
                masked_data[k*8 +: 8] = '0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        load_out   = 1'b0;
        out_status = ST_OK;
        out_len    = '0;
        out_data   = '0;
        out_total  = r_total;
        unique case (r_state)
            BS_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.op)
                        OP_READ: begin
                            n_state = BS_CALC;
                        end
                        OP_NEWLINE: begin
                            load_out  = 1'b1;
                            out_total = can_commit ? r_total + 1'b1 : r_total;
                        end
                        OP_CAPTURE, OP_IGNORE: begin
                            load_out = 1'b1;
                        end
                        default: begin
                            n_state = BS_IDLE;
                        end
                    endcase
                end
            end
            BS_CALC: n_state = BS_SLOT;
            BS_SLOT: n_state = BS_READ;
            BS_READ: n_state = BS_OUT;
            BS_OUT: begin
                load_out   = 1'b1;
                out_status = r_status;
                if (r_status == ST_OK) begin
                    out_len  = r_rd_len;
                    out_data = masked_data;
                end
                n_state = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_cur_len <= '0;
            r_total   <= '0;
            r_wp      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop && (i_cmd.op == OP_CAPTURE) && cap_ok) begin
                r_cur_len <= r_cur_len + 1'b1;
            end
            if (pop && (i_cmd.op == OP_NEWLINE)) begin
                r_cur_len <= '0;
                if (can_commit) begin
                    r_total <= r_total + 1'b1;
                    r_wp    <= (r_wp == LAST_SLT) ? '0 : r_wp + 1'b1;
                end
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_line  <= i_cmd.line;
            r_chunk <= i_cmd.chunk;
        end
        if (r_state == BS_CALC) begin
            r_not_logged <= (r_line >= r_total);
            r_dist       <= r_total - r_line - 1'b1;
        end
        if (r_state == BS_SLOT) begin
            r_status <= calc_status;
            r_slot   <= slot_x[SLOT_W-1:0];
        end
        if (load_out) begin
            r_ostatus <= out_status;
            r_olen    <= out_len;
            r_odata   <= out_data;
            r_ototal  <= out_total;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_line_length = r_olen;
    assign o_chunk_data  = r_odata;
    assign o_lines_total = r_ototal;

endmodule
`default_nettype wire

// ===== hw/rtl/line_log_ring_buffer.sv =====
// Top level of the line log ring buffer.
//
// The slave stream carries commands: tuser is the function (capture a character or read a
// chunk), tdata holds the character, the logical line number and the chunk index. Every
// command gives exactly one transaction on the master stream, in command order: tuser is the
// status, tdata holds the line length, eight chunk bytes and the committed line total.
// Captured characters go straight into a spare ring slot; a newline commits that slot by
// writing its length and advancing the slot pointer, so a commit needs no copy.
// A two-entry command queue decouples the input from the execution unit, which handles one
// command at a time. The execution unit handles a capture, newline or ignored carriage return
// as it accepts it; a read steps through distance, slot and status, memory read and result,
// the memory read step serving the registered read ports of the text and length memories.
// Each result is loaded into the output register as the execution unit finishes it.
// Reset empties the queue and the output register, clears the line total and the current
// length; no memory is cleared. While the master side stalls, the held result keeps the
// execution unit from taking a new command, and the queue fills and then drops tready.
`default_nettype none
module line_log_ring_buffer
    import llrb_pkg::*;
#(
    parameter int RING_LINES = RING_LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,  // char_byte, line_number, chunk_index, zero pad
    input  wire logic         s_axis_tuser,  // func
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata,  // line_length, chunk_data, lines_total
    output logic [1:0]        m_axis_tuser   // status
);

    logic               cmd_valid;
    logic               cmd_ready;
    t_cmd               cmd;
    logic [LEN_W-1:0]   line_length;
    logic [DATA_W-1:0]  chunk_data;
    logic [TOTAL_W-1:0] lines_total;

    llrb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_func        (s_axis_tuser),
        .i_char_byte   (s_axis_tdata[7:0]),
        .i_line_number (s_axis_tdata[39:8]),
        .i_chunk_index (s_axis_tdata[44:40]),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_ready   (cmd_ready)
    );

    llrb_back #(
        .RING_LINES (RING_LINES),
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_ready   (cmd_ready),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (m_axis_tuser),
        .o_line_length (line_length),
        .o_chunk_data  (chunk_data),
        .o_lines_total (lines_total)
    );

    assign m_axis_tdata = {lines_total, chunk_data, line_length};

endmodule
`default_nettype wire

// ===== hw/rtl/llrb_checker.sv =====
// Port-level assertions for the line log ring buffer and their binding.
`default_nettype none
module llrb_checker
    import llrb_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result shown straight after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled result changed.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[71:0] == '0))
        else $error("Failed read carries length or data.");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] <= 8'(LINE_BYTES - 1)))
        else $error("Line length beyond slot size.");

endmodule

bind line_log_ring_buffer llrb_checker #(
    .LINE_BYTES (LINE_BYTES)
) u_llrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
